// ===== rtl/upcn_pkg.sv =====
// Package for the URI percent/case normaliser.
// Holds the escape phase type, character constants, per-word result struct and helpers.
// No dependencies.
package upcn_pkg;

  // Escape tracking phase; the spare code behaves as IDLE
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX1 = 2'd2
  } phase_t;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CASE_GAP = 8'h20;  // 'a' - 'A'

  // Words produced by one input word, slot 0 goes out first
  typedef struct packed {
    logic [1:0]       count;
    logic [2:0]       lasts;
    logic [2:0][7:0]  bytes;
    phase_t           phase_next;
    logic [7:0]       first_next;
  } step_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) v = c - 8'h30;
    else if (c inside {[8'h41:8'h46]}) v = c - 8'h37;
    else if (c inside {[8'h61:8'h66]}) v = c - 8'h57;
    return v[3:0];
  endfunction

  // a..f raised to A..F, anything else unchanged
  function automatic logic [7:0] raise_hex(input logic [7:0] c);
    return (c inside {[8'h61:8'h66]}) ? c - CASE_GAP : c;
  endfunction

  // A..Z lowered, anything else unchanged
  function automatic logic [7:0] lower_alpha(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + CASE_GAP : c;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] x);
    return (x inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                      CH_DASH, CH_DOT, CH_UNDER, CH_TILDE});
  endfunction

endpackage

// ===== rtl/upcn_step.sv =====
// Per-word decision logic: from the current escape phase and the incoming byte,
// works out the 0 to 3 output words and the next phase. Uses upcn_pkg.
module upcn_step (
  input  logic              [7:0] in_byte,
  input  logic                    in_last,
  input  upcn_pkg::phase_t        phase,
  input  logic              [7:0] first_hex,
  output upcn_pkg::step_t         step
);
  import upcn_pkg::*;

  logic [7:0] decoded;
  logic       decode_ok;

  // Candidate decoded character from the two escape bytes
  assign decoded   = {hex_value(first_hex), hex_value(in_byte)};
  assign decode_ok = is_hex(first_hex) && is_hex(in_byte) && is_unreserved(decoded);

  always_comb begin
    step            = '0;
    step.phase_next = PH_IDLE;
    step.first_next = first_hex;
    case (phase)
      PH_PCT: begin
        step.first_next = in_byte;
        if (in_last) begin
          // stream ends after one escape byte: flush '%' and it
          step.count    = 2'd2;
          step.bytes[0] = CH_PCT;
          step.bytes[1] = raise_hex(in_byte);
          step.lasts[1] = 1'b1;
        end else begin
          step.phase_next = PH_HEX1;
        end
      end
      PH_HEX1: begin
        if (decode_ok) begin
          step.count    = 2'd1;
          step.bytes[0] = decoded;
          step.lasts[0] = in_last;
        end else begin
          step.count    = 2'd3;
          step.bytes[0] = CH_PCT;
          step.bytes[1] = raise_hex(first_hex);
          step.bytes[2] = raise_hex(in_byte);
          step.lasts[2] = in_last;
        end
      end
      default: begin
        if (in_byte == CH_PCT) begin
          if (in_last) begin
            // lone '%' at the end of the stream
            step.count    = 2'd1;
            step.bytes[0] = CH_PCT;
            step.lasts[0] = 1'b1;
          end else begin
            step.phase_next = PH_PCT;
          end
        end else begin
          step.count    = 2'd1;
          step.bytes[0] = lower_alpha(in_byte);
          step.lasts[0] = in_last;
        end
      end
    endcase
  end

endmodule

// ===== rtl/uri_percent_case_normalizer.sv =====
// URI percent-encoding and case normaliser, top level.
// Depends on upcn_pkg and upcn_step.
//
// Usage:
//   Slave channel s_*: one URI byte per word, s_tlast on the final byte.
//   Master channel m_*: normalised bytes, m_tlast on the final byte of a URI.
//   Outside an escape A..Z is lowered; a '%' escape whose two hex digits
//   encode an unreserved character is replaced by that character, otherwise
//   '%' and both digits go out with a..f raised. A URI that ends inside an
//   escape flushes the pending bytes.
// The first output word of an accepted input word is registered and shown in the next cycle.
// Throughput: one input word per cycle while each yields at most one output
//   word and m_tready is high; an escape that is kept whole yields three words
//   and holds the input until the three-slot result buffer is down to its last
//   word, as it drains one word a cycle onto the master port while m_tready is high.
// s_tready is high when the result buffer is empty or will be emptied by the
//   word leaving in this cycle, so input and output overlap.
// Reset (rst, synchronous, active high) empties the buffer and returns the
//   escape phase to idle. When m_tready is low, the buffered words hold
//   steady and s_tready falls once a word is waiting.
module uri_percent_case_normalizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);
  import upcn_pkg::*;

  phase_t          phase;
  logic [7:0]      first_hex;
  step_t           step;
  logic [1:0]      cnt;
  logic [2:0][7:0] buf_bytes;
  logic [2:0]      buf_lasts;
  logic            in_acc;
  logic            out_acc;

  upcn_step u_step (
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .phase     (phase),
    .first_hex (first_hex),
    .step      (step)
  );

  // Handshakes
  assign m_tvalid = (cnt != 2'd0);
  assign out_acc  = m_tvalid && m_tready;
  assign s_tready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign m_tdata  = buf_bytes[0];
  assign m_tlast  = buf_lasts[0];

  // Escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      first_hex <= 8'd0;
    end else if (in_acc) begin
      phase     <= step.phase_next;
      first_hex <= step.first_next;
    end
  end

  // Result buffer: loaded whole, drained from slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 2'd0;
      buf_lasts <= 3'b000;
    end else if (in_acc) begin
      cnt       <= step.count;
      buf_lasts <= step.lasts;
    end else if (out_acc) begin
      cnt       <= cnt - 2'd1;
      buf_lasts <= {1'b0, buf_lasts[2:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_bytes <= step.bytes;
    end else if (out_acc) begin
      buf_bytes <= {8'd0, buf_bytes[2:1]};
    end
  end

  // A flagged last word only ever sits alone at the head of the buffer
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> cnt == 2'd1)
    else $error("last word not alone in buffer");

  // A word marked last always closes any open escape
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |=> phase == PH_IDLE)
    else $error("escape left open after last word");

  // Second escape byte is only awaited after the first was taken
  a_hex1_order: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEX1) && ($past(phase) != PH_HEX1) |-> $past(phase) == PH_PCT)
    else $error("phase skipped first escape byte");

  // Plain byte outside an escape yields exactly one word
  a_plain_one: assert property (@(posedge clk) disable iff (rst)
    in_acc && (phase == PH_IDLE) && (s_tdata != CH_PCT) |=> cnt == 2'd1)
    else $error("plain byte did not yield one word");

endmodule
